### src/dats_pkg.sv
// Shared types and constants for the deadline-aware task scheduler.
`timescale 1ns / 1ps
`default_nettype none

package dats_pkg;

  // Field and register widths
  localparam int TIME_W     = 32;
  localparam int PERIOD_W   = 20;
  localparam int PRIO_W     = 2;
  localparam int PRIOS_W    = 8;
  localparam int ENABLE_W   = 4;
  localparam int GUARD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;
  localparam int OUT_IDX_W  = 2;

  // Tasks that own a register slot
  localparam int REG_TASKS = 4;

  // Register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd2000;
  localparam logic [PRIOS_W-1:0]  PRIO_RESET   = 8'd80;
  localparam logic [ENABLE_W-1:0] ENABLE_RESET = 4'hF;
  localparam logic [GUARD_W-1:0]  GUARD_RESET  = 16'd50;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITIES = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD      = 3'd6;

  // Item kinds
  localparam logic KIND_DISPATCH   = 1'b0;
  localparam logic KIND_COMPLETION = 1'b1;

  // Running average: (9*avg + exec) / 10, shift-add reciprocal estimate
  // in three steps plus one remainder step
  localparam int ACC_W          = 36;
  localparam int AVG_DIVISOR    = 10;
  localparam int DIV_STEPS      = 4;
  localparam int DIV_CNT_W      = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELAPSED,
    ST_EVAL,
    ST_DIVIDE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic elapsed;
    logic eval;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
  } dp_status_t;

endpackage

`default_nettype wire

### src/dats_ctrl.sv
// Controller state machine: sequences task scans, division and result commit.
`timescale 1ns / 1ps
`default_nettype none

module dats_ctrl #(
  parameter int TASK_COUNT = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dats_pkg::dp_cmd_t                  cmd,
  output logic [$clog2(TASK_COUNT)-1:0]      task_sel,
  input  wire dats_pkg::dp_status_t          status
);
  import dats_pkg::*;

  localparam int IDX_W = $clog2(TASK_COUNT);

  state_t state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic last_task;
  logic div_last;
  logic commit_ok;

  assign last_task = (task_sel == IDX_W'(TASK_COUNT - 1));
  assign div_last  = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign commit_ok = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_ELAPSED;
      end
      ST_ELAPSED: begin
        state_next = (status.kind == KIND_COMPLETION) ? ST_DIVIDE : ST_EVAL;
      end
      ST_EVAL: begin
        state_next = last_task ? ST_COMMIT : ST_ELAPSED;
      end
      ST_DIVIDE: begin
        if (div_last) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_ok) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ELAPSED: cmd.elapsed  = 1'b1;
      ST_EVAL:    cmd.eval     = 1'b1;
      ST_DIVIDE:  cmd.div_step = 1'b1;
      ST_COMMIT:  cmd.commit   = commit_ok;
      default: ;
    endcase
  end

  // State, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      task_sel  <= '0;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        task_sel <= '0;
        div_cnt  <= '0;
      end
      if (cmd.eval && !last_task) task_sel <= task_sel + 1'b1;
      if (cmd.div_step) div_cnt <= div_cnt + 1'b1;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/dats_datapath.sv
// Datapath: configuration, per-task state, scan evaluation, divide-by-ten unit.
`timescale 1ns / 1ps
`default_nettype none

module dats_datapath #(
  parameter int TASK_COUNT = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dats_pkg::dp_cmd_t                 cmd,
  input  wire logic [$clog2(TASK_COUNT)-1:0]     task_sel,
  output dats_pkg::dp_status_t                   status,
  input  wire logic                              in_kind,
  input  wire logic [dats_pkg::TIME_W-1:0]       in_now,
  input  wire logic [dats_pkg::TIME_W-1:0]       in_exec,
  input  wire logic                              in_completed,
  input  wire logic                              cfg_valid,
  input  wire logic [dats_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dats_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   dispatched,
  output logic [dats_pkg::OUT_IDX_W-1:0]         task_index,
  output logic [dats_pkg::TIME_W-1:0]            avg_exec_us,
  output logic [dats_pkg::TIME_W-1:0]            missed_deadlines
);
  import dats_pkg::*;

  localparam int IDX_W = $clog2(TASK_COUNT);
  localparam int CMP_W = TIME_W + 2;

  // Configuration registers
  logic [PERIOD_W-1:0] period [REG_TASKS];
  logic [PRIOS_W-1:0]  prios;
  logic [ENABLE_W-1:0] enable;
  logic [GUARD_W-1:0]  guard;

  // Per-task state
  logic [TIME_W-1:0]     last_run [TASK_COUNT];
  logic [TIME_W-1:0]     avg_run  [TASK_COUNT];
  logic [TIME_W-1:0]     missed   [TASK_COUNT];
  logic [TASK_COUNT-1:0] marked;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_task;

  // Captured transaction
  logic              kind_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] exec_r;
  logic              completed_r;

  // Scan registers
  logic [TIME_W-1:0]   el;
  logic [PERIOD_W-1:0] slack;
  logic                found;
  logic [IDX_W-1:0]    best;
  logic [PRIO_W-1:0]   best_prio;
  logic [TIME_W-1:0]   best_avg;
  logic [TIME_W-1:0]   best_missed;

  // Divider registers
  logic [ACC_W-1:0] div_x;
  logic [ACC_W-1:0] div_a;
  logic [ACC_W-1:0] div_b;
  logic [ACC_W-1:0] div_c;
  logic [ACC_W-1:0] div_r;

  // Per-task views of the register file
  logic [PERIOD_W-1:0] per_of  [TASK_COUNT];
  logic [PRIO_W-1:0]   base_of [TASK_COUNT];
  logic [TASK_COUNT-1:0] on_of;

  for (genvar g = 0; g < TASK_COUNT; g++) begin : g_task
    if (g < REG_TASKS) begin : g_reg
      assign per_of[g]  = period[g];
      assign base_of[g] = prios[PRIO_W*g +: PRIO_W];
      assign on_of[g]   = enable[g];
    end else begin : g_none
      assign per_of[g]  = PERIOD_RESET;
      assign base_of[g] = '0;
      assign on_of[g]   = 1'b0;
    end
  end

  // Select the task under work
  logic [IDX_W-1:0]    sel;
  logic [PERIOD_W-1:0] per_q;
  logic [TIME_W-1:0]   last_q;
  logic [TIME_W-1:0]   avg_q;
  logic [TIME_W-1:0]   missed_q;

  assign sel      = (kind_r == KIND_COMPLETION) ? pend_task : task_sel;
  assign per_q    = per_of[sel];
  assign last_q   = last_run[sel];
  assign avg_q    = avg_run[sel];
  assign missed_q = missed[sel];

  assign status.kind = kind_r;

  // Threshold compares against multiples of the period
  logic [CMP_W-1:0] el_x, per_x, per2, per3, per4;
  logic per_zero, due, miss_hit;
  logic b1, b2, b3;
  logic [PRIO_W-1:0] boost, dyn;
  logic skip, cand;
  logic [TIME_W:0] need;
  logic [PERIOD_W-1:0] slack_next;
  logic [TIME_W-1:0] missed_new;

  assign el_x     = {2'b00, el};
  assign per_x    = CMP_W'(per_q);
  assign per2     = per_x << 1;
  assign per3     = per_x + per2;
  assign per4     = per_x << 2;
  assign per_zero = (per_q == '0);
  assign due      = (el_x >= per_x);

  // Count a missed deadline once per run
  assign miss_hit   = on_of[sel] && (last_q != '0) && (el_x >= per2) && !marked[sel];
  assign missed_new = missed_q + TIME_W'(miss_hit);

  // Slack until task 0 is next due
  always_comb begin
    if (el < TIME_W'(per_q)) begin
      slack_next = per_q - el[PERIOD_W-1:0];
    end else begin
      slack_next = '0;
    end
  end

  // Skip a non-first task whose budget overruns the slack
  assign need = {1'b0, avg_q} + (TIME_W+1)'(guard);
  assign skip = (sel != '0) && (avg_q != '0) && (need > (TIME_W+1)'(slack));

  // Age by whole periods overdue, clipped at three
  assign b1 = per_zero ? (el != '0)            : (el_x >= per2);
  assign b2 = per_zero ? (el >= TIME_W'(2))    : (el_x >= per3);
  assign b3 = per_zero ? (el >= TIME_W'(3))    : (el_x >= per4);

  always_comb begin
    if (b3) begin
      boost = 2'd3;
    end else if (b2) begin
      boost = 2'd2;
    end else if (b1) begin
      boost = 2'd1;
    end else begin
      boost = 2'd0;
    end
  end

  assign dyn  = (base_of[sel] > boost) ? (base_of[sel] - boost) : '0;
  assign cand = on_of[sel] && due && !skip;

  // Dividend 9*avg + exec
  logic [ACC_W-1:0] dividend;
  assign dividend = {1'b0, avg_q, 3'b000} + ACC_W'(avg_q) + ACC_W'(exec_r);

  // Estimate x/10 as x*0.8/8 by shift-add stages; the estimate is exact or one low
  logic [ACC_W-1:0]  sum_a, sum_b, sum_c;
  logic [TIME_W-1:0] quot;

  assign sum_a = (div_x >> 1) + (div_x >> 2);
  assign sum_b = div_a + (div_a >> 8);
  assign sum_c = div_b + (div_b >> 32);
  assign quot  = div_c[TIME_W-1:0] + TIME_W'(div_r >= ACC_W'(AVG_DIVISOR));

  // Completion: advance or re-anchor the last-run time
  logic [TIME_W-1:0] last_new;
  always_comb begin
    if (last_q == '0 || el_x > per3) begin
      last_new = now_r;
    end else begin
      last_new = last_q + TIME_W'(per_q);
    end
  end

  // Report index at two bits
  logic [IDX_W+1:0] best_ext, pend_ext;
  assign best_ext = {2'b00, best};
  assign pend_ext = {2'b00, pend_task};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REG_TASKS; k++) period[k] <= PERIOD_RESET;
      prios  <= PRIO_RESET;
      enable <= ENABLE_RESET;
      guard  <= GUARD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index) inside
        REG_PERIOD0, REG_PERIOD1, REG_PERIOD2, REG_PERIOD3: begin
          period[cfg_index[1:0]] <= cfg_data;
        end
        REG_PRIORITIES: prios  <= cfg_data[PRIOS_W-1:0];
        REG_ENABLE:     enable <= cfg_data[ENABLE_W-1:0];
        REG_GUARD:      guard  <= cfg_data[GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  // Task state, scan and commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TASK_COUNT; k++) begin
        last_run[k] <= '0;
        avg_run[k]  <= '0;
        missed[k]   <= '0;
      end
      marked     <= '0;
      pend_valid <= 1'b0;
      pend_task  <= '0;
      kind_r     <= KIND_DISPATCH;
      found      <= 1'b0;
      best       <= '0;
      best_prio  <= '0;
    end else begin
      // Capture the transaction
      if (cmd.load) begin
        kind_r      <= in_kind;
        now_r       <= in_now;
        exec_r      <= in_exec;
        completed_r <= in_completed;
        found       <= 1'b0;
        best        <= '0;
        best_prio   <= '0;
      end

      // Elapsed time and dividend
      if (cmd.elapsed) begin
        el    <= now_r - last_q;
        div_x <= dividend;
      end

      // Evaluate one task
      if (cmd.eval) begin
        if (sel == '0) slack <= slack_next;
        if (miss_hit) begin
          missed[sel] <= missed_new;
          marked[sel] <= 1'b1;
        end
        if (cand && (!found || dyn < best_prio)) begin
          found       <= 1'b1;
          best        <= sel;
          best_prio   <= dyn;
          best_avg    <= avg_q;
          best_missed <= missed_new;
        end
      end

      // Advance the divider stages
      if (cmd.div_step) begin
        div_a <= sum_a + (sum_a >> 4);
        div_b <= sum_b + (sum_b >> 16);
        div_c <= sum_c >> 3;
        div_r <= div_x - (div_c << 3) - (div_c << 1);
      end

      // Commit the result
      if (cmd.commit) begin
        if (kind_r == KIND_DISPATCH) begin
          pend_valid       <= found;
          pend_task        <= found ? best : '0;
          dispatched       <= found;
          task_index       <= found ? best_ext[OUT_IDX_W-1:0] : '0;
          avg_exec_us      <= found ? best_avg : '0;
          missed_deadlines <= found ? best_missed : '0;
        end else begin
          pend_valid <= 1'b0;
          if (pend_valid) begin
            if (completed_r) begin
              avg_run[sel]  <= quot;
              last_run[sel] <= last_new;
              marked[sel]   <= 1'b0;
            end
            dispatched       <= 1'b1;
            task_index       <= pend_ext[OUT_IDX_W-1:0];
            avg_exec_us      <= completed_r ? quot : avg_q;
            missed_deadlines <= missed_q;
          end else begin
            dispatched       <= 1'b0;
            task_index       <= '0;
            avg_exec_us      <= '0;
            missed_deadlines <= '0;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### src/deadline_aware_task_scheduler.sv
// A dispatch runs one elapsed and one evaluate state per task in the shared compare
// unit, then the commit state.
// A completion runs the elapsed state, four steps of the divide-by-ten unit, then commit.
// One transaction is in work at a time; the next is accepted the cycle after commit.
// A waiting result does not block the accept but holds the next commit.
// Synchronous reset clears all task state and loads register defaults at once.
`timescale 1ns / 1ps
`default_nettype none

module deadline_aware_task_scheduler #(
  parameter int TASK_COUNT = 4
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [dats_pkg::TIME_W-1:0]       now_us,
  input  wire logic [dats_pkg::TIME_W-1:0]       exec_time_us,
  input  wire logic                              task_completed,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   dispatched,
  output logic [dats_pkg::OUT_IDX_W-1:0]         task_index,
  output logic [dats_pkg::TIME_W-1:0]            avg_exec_us,
  output logic [dats_pkg::TIME_W-1:0]            missed_deadlines,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dats_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dats_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dats_pkg::*;

  localparam int IDX_W = $clog2(TASK_COUNT);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] task_sel;

  // Registers accept a write every cycle
  assign cfg_ready = 1'b1;

  dats_ctrl #(
    .TASK_COUNT (TASK_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .task_sel  (task_sel),
    .status    (status)
  );

  dats_datapath #(
    .TASK_COUNT (TASK_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .task_sel         (task_sel),
    .status           (status),
    .in_kind          (kind),
    .in_now           (now_us),
    .in_exec          (exec_time_us),
    .in_completed     (task_completed),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .dispatched       (dispatched),
    .task_index       (task_index),
    .avg_exec_us      (avg_exec_us),
    .missed_deadlines (missed_deadlines)
  );

endmodule

`default_nettype wire
